FILE: hdl/fqd_pkg.sv
// Shared types, codes and defaults for the FIFO queue with dump.
// No dependencies; every other file of the block refers to this package by scoped names.
package fqd_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int WORD_W        = 32;

	typedef enum logic [1:0] {
		ACT_ENQ  = 2'd0,
		ACT_DEQ  = 2'd1,
		ACT_PEEK = 2'd2,
		ACT_DUMP = 2'd3
	} action_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_OVERFLOW = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;

	typedef struct packed {
		action_t                   action;
		logic signed [WORD_W-1:0]  value;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

endpackage

FILE: hdl/fqd_cmd_if.sv
// Command channel of the FIFO queue: one action and its word per handshake.
// Depends on fqd_pkg.
interface fqd_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            action;
	logic signed [fqd_pkg::WORD_W-1:0]     value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

FILE: hdl/fqd_rsp_if.sv
// Response channel of the FIFO queue: status, word and last flag per handshake.
// Depends on fqd_pkg.
interface fqd_rsp_if;
	logic                                  valid;
	logic                                  ready;
	fqd_pkg::status_t                      status;
	logic signed [fqd_pkg::WORD_W-1:0]     word;
	logic                                  last;

	modport source (output valid, output status, output word, output last, input ready);
	modport sink (input valid, input status, input word, input last, output ready);
endinterface

FILE: hdl/fqd_front.sv
// Front end: accepts commands, decodes the action and holds them in a two-slot job queue.
// Depends on fqd_pkg and fqd_cmd_if.
module fqd_front (
	input  logic              clk,
	input  logic              arst_n,
	fqd_cmd_if.sink           cmd,
	output fqd_pkg::job_req_t req,
	input  logic              pop
);

	fqd_pkg::job_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          take;

	assign cmd.ready = (cnt_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign take      = pop && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (take)
				rd_q <= ~rd_q;
			unique case ({push, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q].action <= fqd_pkg::action_t'(cmd.action);
			slot_q[wr_q].value  <= cmd.value;
		end
	end

	assign req.valid = (cnt_q != 2'd0);
	assign req.job   = slot_q[rd_q];

endmodule

FILE: hdl/fqd_back.sv
// Back end: ring buffer storage, head/tail/occupancy and the response register.
// Depends on fqd_pkg and fqd_rsp_if; takes jobs from fqd_front.
module fqd_back #(
	parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fqd_pkg::job_req_t req,
	output logic              pop,
	fqd_rsp_if.source         rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [fqd_pkg::WORD_W-1:0] mem [DEPTH];
	logic [fqd_pkg::WORD_W-1:0] rd_data_q;

	logic [1:0]    state_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] left_q;

	logic                       rsp_valid_q;
	fqd_pkg::status_t           rsp_status_q;
	logic [fqd_pkg::WORD_W-1:0] rsp_word_q;
	logic                       rsp_last_q;

	logic                       out_free;
	logic                       full;
	logic                       empty;
	logic                       emit;
	logic                       wr_en;
	logic                       start_read;
	fqd_pkg::status_t           e_status;
	logic [fqd_pkg::WORD_W-1:0] e_word;
	logic                       e_last;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign out_free = !rsp_valid_q || rsp.ready;
	assign full     = (occ_q == CW'(DEPTH));
	assign empty    = (occ_q == '0);

	always_comb begin
		emit       = 1'b0;
		pop        = 1'b0;
		wr_en      = 1'b0;
		start_read = 1'b0;
		e_status   = fqd_pkg::ST_OK;
		e_word     = '0;
		e_last     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && out_free) begin
					unique case (req.job.action)
						fqd_pkg::ACT_ENQ: begin
							emit     = 1'b1;
							pop      = 1'b1;
							wr_en    = !full;
							e_status = full ? fqd_pkg::ST_OVERFLOW : fqd_pkg::ST_OK;
						end
						fqd_pkg::ACT_DEQ, fqd_pkg::ACT_PEEK, fqd_pkg::ACT_DUMP: begin
							if (empty) begin
								emit     = 1'b1;
								pop      = 1'b1;
								e_status = fqd_pkg::ST_EMPTY;
							end else begin
								start_read = 1'b1;
							end
						end
					endcase
				end
			end
			S_EMIT: begin
				if (out_free) begin
					emit   = 1'b1;
					e_word = rd_data_q;
					e_last = (req.job.action != fqd_pkg::ACT_DUMP) || (left_q == CW'(1));
					pop    = e_last;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[tail_q] <= req.job.value;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rd_ptr_q    <= '0;
			occ_q       <= '0;
			left_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			if (wr_en) begin
				tail_q <= ring_next(tail_q);
				occ_q  <= occ_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start_read) begin
						rd_ptr_q <= head_q;
						left_q   <= occ_q;
						state_q  <= S_READ;
					end
				end
				S_READ: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit) begin
						if (e_last) begin
							state_q <= S_IDLE;
						end else begin
							rd_ptr_q <= ring_next(rd_ptr_q);
							left_q   <= left_q - 1'b1;
							state_q  <= S_READ;
						end
						if (req.job.action == fqd_pkg::ACT_DEQ) begin
							head_q <= ring_next(head_q);
							occ_q  <= occ_q - 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q <= e_status;
			rsp_word_q   <= e_word;
			rsp_last_q   <= e_last;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.word   = rsp_word_q;
	assign rsp.last   = rsp_last_q;

endmodule

FILE: hdl/fifo_queue_with_dump.sv
// Top level of the FIFO queue with dump; joins fqd_front and fqd_back.
// Depends on fqd_pkg, fqd_cmd_if and fqd_rsp_if.
//
// A queue of DEPTH signed 32-bit words in a ring buffer, driven by commands on cmd and
// answering on rsp. Enqueue, and dequeue, peek or display on an empty queue, are answered
// straight from the idle state of the back end. Dequeue and peek pass through the read and
// emit states, since the stored word comes through the registered read port of the storage
// array. Display does so once per stored entry, oldest first, with last set on the newest,
// for the same reason. A two-slot job queue in the front end keeps taking commands while the
// back end works or rsp stalls, until both slots are full. Storage is not cleared at reset.
module fifo_queue_with_dump #(
	parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	fqd_cmd_if.sink   cmd,
	fqd_rsp_if.source rsp
);

	fqd_pkg::job_req_t req;
	logic              pop;

	fqd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.pop    (pop)
	);

	fqd_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

FILE: test/fqd_checker.sv
`timescale 1ns / 100ps
// Checker for the FIFO queue with dump: tracks the ring, forecasts every answer, compares.
// Depends on fqd_pkg, fqd_cmd_if and fqd_rsp_if; watches both channels without driving them.
module fqd_checker #(
	parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	fqd_cmd_if   cmd,
	fqd_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct {
		fqd_pkg::status_t                  status;
		logic signed [fqd_pkg::WORD_W-1:0] word;
		logic                              last;
	} answer_t;

	logic signed [fqd_pkg::WORD_W-1:0] ring_words [DEPTH];
	int                                head_slot;
	int                                tail_slot;
	int                                fill;
	answer_t                           answers_due [$];

	function automatic int ring_step(int slot);
		return (slot + 1 >= DEPTH) ? 0 : slot + 1;
	endfunction

	function automatic void queue_answer(fqd_pkg::status_t st,
		logic signed [fqd_pkg::WORD_W-1:0] w, logic lst);
		answer_t a;
		a.status = st;
		a.word   = w;
		a.last   = lst;
		answers_due.push_back(a);
	endfunction

	function automatic void forecast_answers(fqd_pkg::action_t act,
		logic signed [fqd_pkg::WORD_W-1:0] v);
		int slot;
		case (act)
			fqd_pkg::ACT_ENQ: begin
				if (fill == DEPTH) begin
					queue_answer(fqd_pkg::ST_OVERFLOW, '0, 1'b1);
				end else begin
					ring_words[tail_slot] = v;
					tail_slot = ring_step(tail_slot);
					fill++;
					queue_answer(fqd_pkg::ST_OK, '0, 1'b1);
				end
			end
			fqd_pkg::ACT_DEQ, fqd_pkg::ACT_PEEK: begin
				if (fill == 0) begin
					queue_answer(fqd_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					queue_answer(fqd_pkg::ST_OK, ring_words[head_slot], 1'b1);
					if (act == fqd_pkg::ACT_DEQ) begin
						head_slot = ring_step(head_slot);
						fill--;
					end
				end
			end
			default: begin
				if (fill == 0) begin
					queue_answer(fqd_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					slot = head_slot;
					for (int k = 0; k < fill; k++) begin
						queue_answer(fqd_pkg::ST_OK, ring_words[slot], k == fill - 1);
						slot = ring_step(slot);
					end
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			head_slot  = 0;
			tail_slot  = 0;
			fill       = 0;
			fail_count = 0;
			answers_due.delete();
			pending    = 0;
		end else begin
			if (cmd.valid && cmd.ready)
				forecast_answers(fqd_pkg::action_t'(cmd.action), cmd.value);
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected word, status %0d word %h last %0b", $time,
						rsp.status, rsp.word, rsp.last);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp.status);
						fail_count++;
					end
					if (rsp.word !== want.word) begin
						$display("%0t: word expected %h actual %h", $time,
							want.word, rsp.word);
						fail_count++;
					end
					if (rsp.last !== want.last) begin
						$display("%0t: last expected %0b actual %0b", $time,
							want.last, rsp.last);
						fail_count++;
					end
				end
			end
			pending = answers_due.size();
		end
	end
endmodule

FILE: test/fifo_queue_with_dump_tb.sv
`timescale 1ns / 100ps
// Top of the FIFO queue with dump testbench: clock, reset, command stimulus and verdict.
// Depends on fqd_pkg, both channel interfaces, fifo_queue_with_dump and fqd_checker.
module fifo_queue_with_dump_tb;

	localparam int DEPTH = fqd_pkg::DEPTH_DEFAULT;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   quiet;
	int   sent;

	fqd_cmd_if cmd ();
	fqd_rsp_if rsp ();

	fifo_queue_with_dump #(.DEPTH(DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	fqd_checker #(.DEPTH(DEPTH)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	// Entered and left at a falling edge; valid stays high into the next word.
	task automatic put_word(fqd_pkg::action_t act, logic signed [fqd_pkg::WORD_W-1:0] v);
		cmd.valid  <= 1'b1;
		cmd.action <= act;
		cmd.value  <= v;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off(int n);
		cmd.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic signed [fqd_pkg::WORD_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(fqd_pkg::WORD_W-1){1'b0}}};
			1: return {1'b0, {(fqd_pkg::WORD_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic fqd_pkg::action_t pick_action(int kind);
		int r;
		r = $urandom_range(0, 19);
		case (kind)
			0: return (r < 16) ? fqd_pkg::ACT_ENQ :
				((r < 18) ? fqd_pkg::ACT_DUMP : fqd_pkg::ACT_PEEK);
			1: return (r < 15) ? fqd_pkg::ACT_DEQ :
				((r < 17) ? fqd_pkg::ACT_PEEK :
				((r < 19) ? fqd_pkg::ACT_DUMP : fqd_pkg::ACT_ENQ));
			default: return fqd_pkg::action_t'(r % 4);
		endcase
	endfunction

	// Ready toggles in bursts; hold it high once the run goes quiet.
	initial begin
		int n;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp.ready <= 1'b0;
				n = $urandom_range(1, 14);
			end else begin
				rsp.ready <= 1'b1;
				n = $urandom_range(1, 20);
			end
			repeat (n) @(negedge clk);
		end
	end

	initial begin
		int kind;
		int len;
		bit paused;
		quiet      = 1'b0;
		paused     = 1'b0;
		sent       = 0;
		cmd.valid  <= 1'b0;
		cmd.action <= fqd_pkg::ACT_ENQ;
		cmd.value  <= '0;
		arst_n     <= 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// empty queue, extremes, fill to full, overflow, full display, peek, dequeue and display
		put_word(fqd_pkg::ACT_DUMP, $urandom);
		put_word(fqd_pkg::ACT_DEQ, $urandom);
		put_word(fqd_pkg::ACT_PEEK, $urandom);
		put_word(fqd_pkg::ACT_ENQ, {1'b0, {(fqd_pkg::WORD_W-1){1'b1}}});
		put_word(fqd_pkg::ACT_ENQ, {1'b1, {(fqd_pkg::WORD_W-1){1'b0}}});
		put_word(fqd_pkg::ACT_ENQ, '0);
		put_word(fqd_pkg::ACT_ENQ, '1);
		put_word(fqd_pkg::ACT_ENQ, 32'h5555_5555);
		put_word(fqd_pkg::ACT_ENQ, 32'hAAAA_AAAA);
		for (int i = 6; i < DEPTH; i++)
			put_word(fqd_pkg::ACT_ENQ, $urandom);
		put_word(fqd_pkg::ACT_ENQ, $urandom);
		put_word(fqd_pkg::ACT_DUMP, $urandom);
		put_word(fqd_pkg::ACT_PEEK, $urandom);
		put_word(fqd_pkg::ACT_DEQ, $urandom);
		put_word(fqd_pkg::ACT_DUMP, $urandom);
		wait_drained();

		// runs of filling, draining and mixed traffic
		while (sent < 86) begin
			kind = (sent == 0) ? 1 : $urandom_range(0, 2);
			len  = (kind == 2) ? 10 : DEPTH + 2;
			for (int i = 0; i < len && sent < 86; i++) begin
				if (sent >= 70)
					quiet = 1'b1;
				if (!quiet && $urandom_range(0, 4) == 0)
					hold_off($urandom_range(1, 14));
				put_word(pick_action(kind), pick_value());
				sent++;
				if (!paused && sent >= 40) begin
					paused = 1'b1;
					wait_drained();
				end
			end
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

FILE: files.f
hdl/fqd_pkg.sv
hdl/fqd_cmd_if.sv
hdl/fqd_rsp_if.sv
hdl/fqd_front.sv
hdl/fqd_back.sv
hdl/fifo_queue_with_dump.sv
test/fqd_checker.sv
test/fifo_queue_with_dump_tb.sv
